// File: hw/rtl/csfb_pkg.sv
// Package for the sync/length/CRC-32 frame builder: constants, byte positions and CRC step.
package csfb_pkg;

	localparam int unsigned LEN_BITS = 16;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [7:0] SYNC_0 = 8'hFE;
	localparam logic [7:0] SYNC_1 = 8'hED;
	localparam logic [7:0] SYNC_2 = 8'hFA;
	localparam logic [7:0] SYNC_3 = 8'hCE;

	typedef enum logic [4:0] {
		POS_SYNC0,
		POS_SYNC1,
		POS_SYNC2,
		POS_SYNC3,
		POS_SEQ0,
		POS_SEQ1,
		POS_SEQ2,
		POS_SEQ3,
		POS_KIND,
		POS_LEN0,
		POS_LEN1,
		POS_LEN2,
		POS_LEN3,
		POS_PAYLOAD,
		POS_CRC0,
		POS_CRC1,
		POS_CRC2,
		POS_CRC3
	} pos_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/crc32_sync_frame_builder_top.sv
// Top level of the sync/length/CRC-32 frame builder.
//
// The input channel (in_valid, in_stall) takes one payload byte per item with
// its is_first and is_last flags and, on the first byte, the frame length. The
// output channel (out_valid, out_stall) gives one framed byte per item. An
// input item flagged first is preceded by the 13-byte header (sync FE ED FA CE,
// sequence number, type byte, length); one flagged last is followed by the
// four CRC bytes, the last of which carries frame_done. run_last marks the
// final output byte caused by each input item.
// An input item yields 1 to 18 output bytes, one per cycle, set by the single
// byte sequencer that walks the header, payload and CRC positions; a plain
// payload byte therefore sustains one item per cycle. The next input item is
// accepted in the same cycle as the last byte of the current one is moved to
// the output register. The stream kind (kind_q) is written through
// cfg_valid/cfg_ready; the user must write it only while idle, as the block
// does not enforce this. Reset clears the sequence number to zero, the CRC
// to all ones and the type to zero. While out_stall is high and out_valid
// is set, the output register keeps its byte and the sequencer and input wait.
module crc32_sync_frame_builder_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   payload_byte,
	input  logic                         is_first,
	input  logic                         is_last,
	input  logic [csfb_pkg::LEN_BITS-1:0] frame_length,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   out_byte,
	output logic                         frame_done,
	output logic                         run_last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_data
);

	logic                          busy_q;
	csfb_pkg::pos_t                pos_q;
	logic [7:0]                    byte_q;
	logic                          last_q;
	logic [csfb_pkg::LEN_BITS-1:0] len_q;
	logic [31:0]                   seq_q;
	logic [31:0]                   crc_q;
	logic [1:0]                    kind_q;
	logic                          ov_q;
	logic [7:0]                    out_byte_q;
	logic                          frame_done_q;
	logic                          run_last_q;

	logic           advance;
	logic           is_end;
	logic           accept;
	logic [7:0]     cur_byte;
	logic [31:0]    len32;
	logic [31:0]    crc_out;
	logic [31:0]    crc_base;
	csfb_pkg::pos_t end_pos;
	logic           busy_d;
	csfb_pkg::pos_t pos_d;

	assign cfg_ready = 1'b1;
	assign len32     = 32'(len_q);
	assign crc_out   = ~crc_q;
	assign end_pos   = last_q ? csfb_pkg::POS_CRC3 : csfb_pkg::POS_PAYLOAD;
	assign is_end    = (pos_q == end_pos);
	assign advance   = busy_q && (!ov_q || !out_stall);
	assign in_stall  = busy_q && !(advance && is_end);
	assign accept    = in_valid && !in_stall;
	assign crc_base  = (pos_q == csfb_pkg::POS_SEQ0) ? csfb_pkg::CRC_INIT : crc_q;

	always_comb begin
		case (pos_q)
			csfb_pkg::POS_SYNC0:   cur_byte = csfb_pkg::SYNC_0;
			csfb_pkg::POS_SYNC1:   cur_byte = csfb_pkg::SYNC_1;
			csfb_pkg::POS_SYNC2:   cur_byte = csfb_pkg::SYNC_2;
			csfb_pkg::POS_SYNC3:   cur_byte = csfb_pkg::SYNC_3;
			csfb_pkg::POS_SEQ0:    cur_byte = seq_q[7:0];
			csfb_pkg::POS_SEQ1:    cur_byte = seq_q[15:8];
			csfb_pkg::POS_SEQ2:    cur_byte = seq_q[23:16];
			csfb_pkg::POS_SEQ3:    cur_byte = seq_q[31:24];
			csfb_pkg::POS_KIND:    cur_byte = {6'd0, kind_q};
			csfb_pkg::POS_LEN0:    cur_byte = len32[7:0];
			csfb_pkg::POS_LEN1:    cur_byte = len32[15:8];
			csfb_pkg::POS_LEN2:    cur_byte = len32[23:16];
			csfb_pkg::POS_LEN3:    cur_byte = len32[31:24];
			csfb_pkg::POS_PAYLOAD: cur_byte = byte_q;
			csfb_pkg::POS_CRC0:    cur_byte = crc_out[7:0];
			csfb_pkg::POS_CRC1:    cur_byte = crc_out[15:8];
			csfb_pkg::POS_CRC2:    cur_byte = crc_out[23:16];
			csfb_pkg::POS_CRC3:    cur_byte = crc_out[31:24];
			default:               cur_byte = byte_q;
		endcase
	end

	always_comb begin
		busy_d = busy_q;
		pos_d  = pos_q;
		if (advance) begin
			if (!is_end) begin
				pos_d = csfb_pkg::pos_t'(5'(pos_q) + 5'd1);
			end else begin
				busy_d = 1'b0;
			end
		end
		if (accept) begin
			busy_d = 1'b1;
			pos_d  = is_first ? csfb_pkg::POS_SYNC0 : csfb_pkg::POS_PAYLOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= csfb_pkg::POS_PAYLOAD;
			seq_q  <= 32'd0;
			crc_q  <= csfb_pkg::CRC_INIT;
			kind_q <= 2'd0;
			ov_q   <= 1'b0;
		end else begin
			busy_q <= busy_d;
			pos_q  <= pos_d;
			if (cfg_valid && cfg_ready) begin
				kind_q <= cfg_data;
			end
			if (advance) begin
				ov_q <= 1'b1;
				if (pos_q inside {[csfb_pkg::POS_SEQ0:csfb_pkg::POS_PAYLOAD]}) begin
					crc_q <= csfb_pkg::crc_byte(crc_base, cur_byte);
				end
				if (pos_q == csfb_pkg::POS_CRC3) begin
					crc_q <= csfb_pkg::CRC_INIT;
					seq_q <= seq_q + 32'd1;
				end
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= payload_byte;
			last_q <= is_last;
			if (is_first) begin
				len_q <= frame_length;
			end
		end
		if (advance) begin
			out_byte_q   <= cur_byte;
			frame_done_q <= (pos_q == csfb_pkg::POS_CRC3);
			run_last_q   <= is_end;
		end
	end

	assign out_valid  = ov_q;
	assign out_byte   = out_byte_q;
	assign frame_done = frame_done_q;
	assign run_last   = run_last_q;

endmodule

// File: tb/crc32_sync_frame_builder_top_test.sv
// Self-checking testbench for the sync/length/CRC-32 frame builder top level.
module crc32_sync_frame_builder_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          PHASE_ITEMS = 104;

	typedef logic [csfb_pkg::LEN_BITS-1:0] len_t;

	typedef struct packed {
		logic [7:0] b;
		logic       done;
		logic       last;
	} framed_t;

	typedef struct {
		logic [7:0] pb;
		logic       f;
		logic       l;
		len_t       fl;
		int         want_n;
		logic [7:0] want_b0;
	} dir_row_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] payload_byte = 8'h00;
	logic       is_first     = 1'b0;
	logic       is_last      = 1'b0;
	len_t       frame_length = '0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [7:0] out_byte;
	logic       frame_done;
	logic       run_last;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_data     = 2'd0;

	logic [31:0] seq_no   = 32'd0;
	logic [31:0] crc_run  = csfb_pkg::CRC_INIT;
	logic [1:0]  kind_reg = 2'd0;

	framed_t     expected_bytes[$];
	framed_t     run_buf[18];
	int          run_cnt;
	int          err_cnt    = 0;
	int          burst_left = 0;
	int unsigned cyc        = 0;
	int          hold_left  = 0;
	logic        hold_go    = 1'b0;
	logic        hold_done  = 1'b0;

	dir_row_t dir_rows[14] = '{
		'{8'h00, 1'b0, 1'b0, 16'h0001,  1, 8'h00},
		'{8'hFF, 1'b1, 1'b1, 16'h0001, 18, 8'hFE},
		'{8'h00, 1'b1, 1'b0, 16'hFFFF, 14, 8'hFE},
		'{8'hAA, 1'b0, 1'b0, 16'h0000,  1, 8'hAA},
		'{8'h55, 1'b0, 1'b1, 16'h0000,  5, 8'h55},
		'{8'h12, 1'b1, 1'b0, 16'h0000, 14, 8'hFE},
		'{8'h34, 1'b1, 1'b0, 16'h0003, 14, 8'hFE},
		'{8'h56, 1'b0, 1'b0, 16'h5555,  1, 8'h56},
		'{8'h78, 1'b0, 1'b1, 16'hAAAA,  5, 8'h78},
		'{8'h80, 1'b0, 1'b1, 16'h0000,  5, 8'h80},
		'{8'h7F, 1'b1, 1'b1, 16'h8000, 18, 8'hFE},
		'{8'h01, 1'b1, 1'b0, 16'h00FF,  0, 8'h00},
		'{8'hFE, 1'b0, 1'b0, 16'h1234,  0, 8'h00},
		'{8'hCE, 1'b0, 1'b1, 16'hEDCB,  0, 8'h00}
	};

	crc32_sync_frame_builder_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.payload_byte (payload_byte),
		.is_first     (is_first),
		.is_last      (is_last),
		.frame_length (frame_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.frame_done   (frame_done),
		.run_last     (run_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] acc;
		logic        fb;
		acc = c;
		for (int i = 0; i < 8; i++) begin
			fb  = acc[0] ^ d[i];
			acc = acc >> 1;
			if (fb) begin
				acc = acc ^ csfb_pkg::CRC_POLY;
			end
		end
		return acc;
	endfunction

	function automatic void run_add(input logic [7:0] b, input logic done, input logic fold);
		if (fold) begin
			crc_run = crc_fold(crc_run, b);
		end
		run_buf[run_cnt] = {b, done, 1'b0};
		run_cnt++;
	endfunction

	// Works out the framed bytes that one accepted item gives and queues them.
	task automatic frame_predict(input logic [7:0] pb, input logic f, input logic l,
			input len_t fl, output int n, output logic [7:0] b0);
		logic [31:0] len32;
		logic [31:0] fcs;
		run_cnt = 0;
		len32   = 32'(fl);
		if (f) begin
			run_add(csfb_pkg::SYNC_0, 1'b0, 1'b0);
			run_add(csfb_pkg::SYNC_1, 1'b0, 1'b0);
			run_add(csfb_pkg::SYNC_2, 1'b0, 1'b0);
			run_add(csfb_pkg::SYNC_3, 1'b0, 1'b0);
			crc_run = csfb_pkg::CRC_INIT;
			for (int i = 0; i < 4; i++) begin
				run_add(seq_no[8*i +: 8], 1'b0, 1'b1);
			end
			run_add({6'd0, kind_reg}, 1'b0, 1'b1);
			for (int i = 0; i < 4; i++) begin
				run_add(len32[8*i +: 8], 1'b0, 1'b1);
			end
		end
		run_add(pb, 1'b0, 1'b1);
		if (l) begin
			fcs = ~crc_run;
			for (int i = 0; i < 4; i++) begin
				run_add(fcs[8*i +: 8], i == 3, 1'b0);
			end
			seq_no  = seq_no + 32'd1;
			crc_run = csfb_pkg::CRC_INIT;
		end
		run_buf[run_cnt-1].last = 1'b1;
		for (int i = 0; i < run_cnt; i++) begin
			expected_bytes.push_back(run_buf[i]);
		end
		n  = run_cnt;
		b0 = run_buf[0].b;
	endtask

	task automatic send_byte(input logic [7:0] pb, input logic f, input logic l,
			input len_t fl, output int n, output logic [7:0] b0);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid     <= 1'b1;
		payload_byte <= pb;
		is_first     <= f;
		is_last      <= l;
		frame_length <= fl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		frame_predict(pb, f, l, fl, n, b0);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic kind_write(input logic [1:0] k);
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		kind_reg   = k;
	endtask

	task automatic random_frames(input int target);
		int         got;
		int         len;
		int         sel;
		int         n;
		logic [7:0] b0;
		len_t       lf;
		got = 0;
		while (got < target) begin
			sel = $urandom_range(0, 9);
			if (sel <= 6) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
				lf  = ($urandom_range(0, 5) == 0) ? len_t'($urandom) : len_t'(len);
				for (int i = 0; i < len; i++) begin
					send_byte(8'($urandom), i == 0, i == len - 1,
						(i == 0) ? lf : len_t'($urandom), n, b0);
				end
				got += len;
			end else if (sel == 7) begin
				send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), len_t'($urandom), n, b0);
				got += 1;
			end else if (sel == 8) begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++) begin
					send_byte(8'($urandom), i == 0, 1'b0, len_t'($urandom), n, b0);
				end
				got += len;
			end else begin
				send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					len_t'($urandom), n, b0);
				got += 1;
			end
		end
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("crc32_sync_frame_builder_top_test: errors");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= 150;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			case (cyc[8:7])
				2'd0: out_stall <= 1'b0;
				2'd1: out_stall <= ($urandom_range(0, 3) == 0);
				2'd2: out_stall <= (cyc[2:0] > 3'd4);
				default: out_stall <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin : check_out
		framed_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("out_byte: nothing expected, got %02h", out_byte);
				err_cnt++;
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.b) begin
					$error("out_byte: expected %02h, got %02h", want.b, out_byte);
					err_cnt++;
				end
				if (frame_done !== want.done) begin
					$error("frame_done: expected %0b, got %0b", want.done, frame_done);
					err_cnt++;
				end
				if (run_last !== want.last) begin
					$error("run_last: expected %0b, got %0b", want.last, run_last);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		int          n;
		logic [7:0]  b0;
		logic [1:0]  kinds[4];
		kinds = '{2'd2, 2'd1, 2'd3, 2'd0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed rows run with the type left at its reset value.
		foreach (dir_rows[r]) begin
			send_byte(dir_rows[r].pb, dir_rows[r].f, dir_rows[r].l, dir_rows[r].fl, n, b0);
			if (dir_rows[r].want_n != 0) begin
				if (n != dir_rows[r].want_n) begin
					$error("result count: expected %0d, got %0d", dir_rows[r].want_n, n);
					err_cnt++;
				end
				if (b0 !== dir_rows[r].want_b0) begin
					$error("first out_byte: expected %02h, got %02h", dir_rows[r].want_b0, b0);
					err_cnt++;
				end
			end
		end

		foreach (kinds[p]) begin
			wait_idle();
			kind_write(kinds[p]);
			if (p == 1) begin
				hold_go = 1'b1;
			end
			random_frames(PHASE_ITEMS);
		end

		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0) begin
			$display("crc32_sync_frame_builder_top_test: clean");
		end else begin
			$display("crc32_sync_frame_builder_top_test: errors");
		end
		$finish;
	end

endmodule
